// ===== src/smf3_pkg.sv =====
// Shared types and constants for the 3x3 slice median filter.
// No dependencies; used by slice_median_filter_3x3_unit.
`default_nettype none

package smf3_pkg;

    // Line store depth and sample format
    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 32;
    localparam int ADDR_BITS   = $clog2(MAX_WIDTH);

    // Configuration register widths
    localparam int COL_BITS = 11;
    localparam int ROW_BITS = 16;

    // Result queue sizing: items between the input register and the queue
    localparam int FIFO_DEPTH    = 16;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);
    localparam int IN_FLIGHT_MAX = 5;

    // APB word addresses of the configuration registers
    localparam int APB_ADDR_BITS = 4;
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_FILTER_ENABLE = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // One result item as held in the output queue
    typedef struct packed {
        sample_t value;
        logic    passed;
        logic    last;
    } result_t;

    // Median of three by signed ordering
    function automatic sample_t med3(input sample_t a, input sample_t b, input sample_t c);
        logic ab;
        logic ac;
        logic bc;
        sample_t m;
        ab = a > b;
        ac = a > c;
        bc = b > c;
        if (ab != ac) begin
            m = a;
        end else if (ab == bc) begin
            m = b;
        end else begin
            m = c;
        end
        return m;
    endfunction

    function automatic sample_t min3(input sample_t a, input sample_t b, input sample_t c);
        sample_t m;
        m = (a < b) ? a : b;
        return (c < m) ? c : m;
    endfunction

    function automatic sample_t max3(input sample_t a, input sample_t b, input sample_t c);
        sample_t m;
        m = (a > b) ? a : b;
        return (c > m) ? c : m;
    endfunction

endpackage

`default_nettype wire

// ===== src/slice_median_filter_3x3_unit.sv =====
// Streaming 3x3 median filter over slices of a volume, with APB configuration.
// Depends on smf3_pkg (types, sizes, register addresses, median helpers).
//
// Takes one pixel per clock and gives one result per clock in steady state,
// while the result side keeps taking results. A pixel's result leaves with
// the input item image_width + 1 items later; pad items (s_tuser = 1) push
// out the tail. Inside the block an item passes the line store read, the
// read-modify-write of the two line stores and the window, and the compare
// network (column sort, combine, median of three) before it lands in a
// 16-entry result queue. Input is taken while the queue has room for
// every item in flight, so a stalled output side stops the input side only
// once twelve results are waiting. The line stores come up undefined
// and need no clearing after reset. Reconfigure only while the block is idle.
`default_nettype none

module slice_median_filter_3x3_unit (
    input  wire                                     aclk,
    input  wire                                     aresetn,
    // input channel
    input  wire                                     s_tvalid,
    output logic                                    s_tready,
    input  wire  [smf3_pkg::SAMPLE_BITS-1:0]        s_tdata,   // [31:0] sample
    input  wire                                     s_tuser,   // [0] pad
    // result channel
    output logic                                    m_tvalid,
    input  wire                                     m_tready,
    output logic [smf3_pkg::SAMPLE_BITS-1:0]        m_tdata,   // [31:0] filtered_value
    output logic                                    m_tuser,   // [0] passed_through
    output logic                                    m_tlast,   // end_of_slice
    // configuration port
    input  wire                                     psel,
    input  wire                                     penable,
    input  wire                                     pwrite,
    input  wire  [smf3_pkg::APB_ADDR_BITS-1:0]      paddr,
    input  wire  [31:0]                             pwdata,
    output logic [31:0]                             prdata,
    output logic                                    pready
);

    localparam int CB = smf3_pkg::COL_BITS;
    localparam int RB = smf3_pkg::ROW_BITS;
    localparam int AB = smf3_pkg::ADDR_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CB-1:0] cfg_width_reg;
    logic [RB-1:0] cfg_height_reg;
    logic          cfg_enable_reg;
    logic          apb_wr;

    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= CB'(256);
            cfg_height_reg <= RB'(256);
            cfg_enable_reg <= 1'b1;
        end else if (apb_wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                smf3_pkg::REG_IMAGE_WIDTH:   cfg_width_reg  <= pwdata[CB-1:0];
                smf3_pkg::REG_IMAGE_HEIGHT:  cfg_height_reg <= pwdata[RB-1:0];
                smf3_pkg::REG_FILTER_ENABLE: cfg_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        prdata = 32'd0;
        unique case (paddr[3:2])
            smf3_pkg::REG_IMAGE_WIDTH:   prdata = {{(32-CB){1'b0}}, cfg_width_reg};
            smf3_pkg::REG_IMAGE_HEIGHT:  prdata = {{(32-RB){1'b0}}, cfg_height_reg};
            smf3_pkg::REG_FILTER_ENABLE: prdata = {31'd0, cfg_enable_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // Effective frame size: zero acts as one, width clamps to the line store
    logic [CB-1:0] w_eff;
    logic [RB-1:0] h_eff;

    always_comb begin
        if (cfg_width_reg == '0) begin
            w_eff = CB'(1);
        end else if (cfg_width_reg > CB'(smf3_pkg::MAX_WIDTH)) begin
            w_eff = CB'(smf3_pkg::MAX_WIDTH);
        end else begin
            w_eff = cfg_width_reg;
        end
        h_eff = (cfg_height_reg == '0) ? RB'(1) : cfg_height_reg;
    end

    // ------------------------------------------------------------------
    // Accept stage: position counters, emit decision, line store read
    // ------------------------------------------------------------------
    logic [smf3_pkg::FIFO_CNT_BITS-1:0] fifo_cnt_reg;
    logic [CB-1:0] col_reg, col_next;
    logic [RB-1:0] row_reg, row_next;
    logic [CB-1:0] pend_reg, pend_next;

    logic                  s_acc;
    logic                  op;
    logic                  pad;
    smf3_pkg::sample_t     px;
    logic [CB-1:0]         c_cur;
    logic [RB-1:0]         r_cur;
    logic [CB-1:0]         ocol;
    logic [RB-1:0]         orow;
    logic signed [RB+1:0]  rdiff;
    logic signed [RB+1:0]  hx;
    logic                  emit;
    logic                  interior;
    logic                  eos;
    logic [AB-1:0]         a_addr;

    assign s_tready = fifo_cnt_reg <=
                      smf3_pkg::FIFO_CNT_BITS'(smf3_pkg::FIFO_DEPTH - smf3_pkg::IN_FLIGHT_MAX);
    assign s_acc    = s_tvalid && s_tready;
    assign pad      = s_tuser;
    assign px       = pad ? '0 : smf3_pkg::sample_t'(s_tdata);
    // A pad with nothing pending is dropped without any effect
    assign op       = s_acc && !(pad && pend_reg == '0);

    always_comb begin
        c_cur  = (col_reg >= w_eff) ? '0 : col_reg;
        r_cur  = (row_reg >= h_eff) ? '0 : row_reg;
        a_addr = c_cur[AB-1:0];
        hx     = $signed({2'b00, h_eff});

        // Position of the pixel reaching the window center
        if (c_cur == '0) begin
            ocol  = w_eff - CB'(1);
            rdiff = $signed({2'b00, r_cur}) - 18'sd2;
        end else begin
            ocol  = c_cur - CB'(1);
            rdiff = $signed({2'b00, r_cur}) - 18'sd1;
        end
        if (rdiff >= 0) begin
            orow = rdiff[RB-1:0];
        end else if (rdiff + hx >= 0) begin
            orow = RB'(rdiff + hx);
        end else begin
            orow = RB'(rdiff + hx + hx);
        end

        // Emit decision and pending count
        pend_next = pend_reg;
        emit      = 1'b0;
        if (pad) begin
            emit      = 1'b1;
            pend_next = pend_reg - CB'(1);
        end else if ({1'b0, pend_reg} >= {1'b0, w_eff} + (CB+1)'(1)) begin
            emit      = 1'b1;
            pend_next = w_eff + CB'(1);
        end else begin
            pend_next = pend_reg + CB'(1);
        end

        // Advance the raster position
        if ({1'b0, c_cur} + (CB+1)'(1) >= {1'b0, w_eff}) begin
            col_next = '0;
            row_next = ({1'b0, r_cur} + (RB+1)'(1) >= {1'b0, h_eff}) ? '0 : r_cur + RB'(1);
        end else begin
            col_next = c_cur + CB'(1);
            row_next = r_cur;
        end
        if (pad && pend_next == '0) begin
            col_next = '0;
            row_next = '0;
        end

        interior = cfg_enable_reg && w_eff >= CB'(3) && h_eff >= RB'(3) &&
                   ocol != '0 && ({1'b0, ocol} + (CB+1)'(2) <= {1'b0, w_eff}) &&
                   orow != '0 && ({1'b0, orow} + (RB+1)'(2) <= {1'b0, h_eff});
        eos      = (orow == h_eff - RB'(1)) && (ocol == w_eff - CB'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
        end else if (op) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: synchronous read at accept, write back in the next cycle, no later
    // ------------------------------------------------------------------
    smf3_pkg::sample_t up_mem  [smf3_pkg::MAX_WIDTH];
    smf3_pkg::sample_t mid_mem [smf3_pkg::MAX_WIDTH];
    smf3_pkg::sample_t rd_up_reg;
    smf3_pkg::sample_t rd_mid_reg;

    logic              b_vld_reg;
    logic              b_emit_reg;
    logic              b_interior_reg;
    logic              b_eos_reg;
    smf3_pkg::sample_t b_px_reg;
    logic [AB-1:0]     b_addr_reg;

    logic              fwd_hit_reg;
    smf3_pkg::sample_t fwd_up_reg;
    smf3_pkg::sample_t fwd_mid_reg;

    smf3_pkg::sample_t up_eff;
    smf3_pkg::sample_t mid_eff;

    // Take the write of the item just ahead when it hit the same column
    assign up_eff  = fwd_hit_reg ? fwd_up_reg  : rd_up_reg;
    assign mid_eff = fwd_hit_reg ? fwd_mid_reg : rd_mid_reg;

    always_ff @(posedge aclk) begin
        if (op) begin
            rd_up_reg  <= up_mem[a_addr];
            rd_mid_reg <= mid_mem[a_addr];
        end
        if (b_vld_reg) begin
            up_mem[b_addr_reg]  <= mid_eff;
            mid_mem[b_addr_reg] <= b_px_reg;
        end
    end

    // Item registers of the read-modify-write stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg   <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else begin
            b_vld_reg   <= op;
            fwd_hit_reg <= op && b_vld_reg && (b_addr_reg == a_addr);
        end
        fwd_up_reg     <= mid_eff;
        fwd_mid_reg    <= b_px_reg;
        b_emit_reg     <= emit;
        b_interior_reg <= interior;
        b_eos_reg      <= eos;
        b_px_reg       <= px;
        b_addr_reg     <= a_addr;
    end

    // ------------------------------------------------------------------
    // 3x3 window: shift left, insert the new column
    // ------------------------------------------------------------------
    smf3_pkg::sample_t win_reg [9];
    logic              w_vld_reg;
    logic              w_interior_reg;
    logic              w_eos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
            w_vld_reg <= 1'b0;
        end else begin
            w_vld_reg <= b_vld_reg && b_emit_reg;
            if (b_vld_reg) begin
                for (int i = 0; i < 3; i++) begin
                    win_reg[i*3]     <= win_reg[i*3 + 1];
                    win_reg[i*3 + 1] <= win_reg[i*3 + 2];
                end
                win_reg[2] <= up_eff;
                win_reg[5] <= mid_eff;
                win_reg[8] <= b_px_reg;
            end
        end
        w_interior_reg <= b_interior_reg;
        w_eos_reg      <= b_eos_reg;
    end

    // ------------------------------------------------------------------
    // Median network: sort columns, combine, then median of three
    // ------------------------------------------------------------------
    smf3_pkg::sample_t s1_lo_reg [3];
    smf3_pkg::sample_t s1_md_reg [3];
    smf3_pkg::sample_t s1_hi_reg [3];
    smf3_pkg::sample_t s1_ctr_reg;
    logic              s1_vld_reg;
    logic              s1_interior_reg;
    logic              s1_eos_reg;

    smf3_pkg::sample_t s2_lo_reg;
    smf3_pkg::sample_t s2_md_reg;
    smf3_pkg::sample_t s2_hi_reg;
    smf3_pkg::sample_t s2_ctr_reg;
    logic              s2_vld_reg;
    logic              s2_interior_reg;
    logic              s2_eos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= w_vld_reg;
            s2_vld_reg <= s1_vld_reg;
        end
        // sort each column of three
        for (int k = 0; k < 3; k++) begin
            s1_lo_reg[k] <= smf3_pkg::min3(win_reg[k], win_reg[k+3], win_reg[k+6]);
            s1_md_reg[k] <= smf3_pkg::med3(win_reg[k], win_reg[k+3], win_reg[k+6]);
            s1_hi_reg[k] <= smf3_pkg::max3(win_reg[k], win_reg[k+3], win_reg[k+6]);
        end
        s1_ctr_reg      <= win_reg[4];
        s1_interior_reg <= w_interior_reg;
        s1_eos_reg      <= w_eos_reg;
        // largest low, middle median, smallest high
        s2_lo_reg       <= smf3_pkg::max3(s1_lo_reg[0], s1_lo_reg[1], s1_lo_reg[2]);
        s2_md_reg       <= smf3_pkg::med3(s1_md_reg[0], s1_md_reg[1], s1_md_reg[2]);
        s2_hi_reg       <= smf3_pkg::min3(s1_hi_reg[0], s1_hi_reg[1], s1_hi_reg[2]);
        s2_ctr_reg      <= s1_ctr_reg;
        s2_interior_reg <= s1_interior_reg;
        s2_eos_reg      <= s1_eos_reg;
    end

    smf3_pkg::result_t res;

    always_comb begin
        res.value  = s2_interior_reg ? smf3_pkg::med3(s2_lo_reg, s2_md_reg, s2_hi_reg)
                                     : s2_ctr_reg;
        res.passed = !s2_interior_reg;
        res.last   = s2_eos_reg;
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    smf3_pkg::result_t                  fifo_mem [smf3_pkg::FIFO_DEPTH];
    logic [smf3_pkg::FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [smf3_pkg::FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic                               push;
    logic                               pop;
    smf3_pkg::result_t                  head;

    assign push     = s2_vld_reg;
    assign m_tvalid = fifo_cnt_reg != '0;
    assign pop      = m_tvalid && m_tready;
    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tdata  = head.value;
    assign m_tuser  = head.passed;
    assign m_tlast  = head.last;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + smf3_pkg::FIFO_PTR_BITS'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + smf3_pkg::FIFO_PTR_BITS'(1);
            end
            if (push && !pop) begin
                fifo_cnt_reg <= fifo_cnt_reg + smf3_pkg::FIFO_CNT_BITS'(1);
            end else if (pop && !push) begin
                fifo_cnt_reg <= fifo_cnt_reg - smf3_pkg::FIFO_CNT_BITS'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking bench for slice_median_filter_3x3_unit: streams pixel volumes through the
// block and checks each result against an in-bench 3x3 median predictor.
// Depends on smf3_pkg and the unit's RTL; no files or arguments.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PIXELS = 400;
    localparam int WIDE_PIXELS   = 24;
    localparam int MAX_PRINTS    = 40;

    logic                                   aclk;
    logic                                   aresetn;
    logic                                   s_tvalid;
    logic                                   s_tready;
    logic [smf3_pkg::SAMPLE_BITS-1:0]       s_tdata;   // [31:0] sample
    logic                                   s_tuser;   // [0] pad
    logic                                   m_tvalid;
    logic                                   m_tready;
    logic [smf3_pkg::SAMPLE_BITS-1:0]       m_tdata;   // [31:0] filtered_value
    logic                                   m_tuser;   // [0] passed_through
    logic                                   m_tlast;   // end_of_slice
    logic                                   psel;
    logic                                   penable;
    logic                                   pwrite;
    logic [smf3_pkg::APB_ADDR_BITS-1:0]     paddr;
    logic [31:0]                            pwdata;
    logic [31:0]                            prdata;
    logic                                   pready;

    slice_median_filter_3x3_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predictor state: configuration, line stores, window and stream position
    logic [smf3_pkg::COL_BITS-1:0] cfg_width  = 11'd256;
    logic [smf3_pkg::ROW_BITS-1:0] cfg_height = 16'd256;
    logic                          cfg_filter = 1'b1;
    smf3_pkg::sample_t             upper_row [smf3_pkg::MAX_WIDTH];
    smf3_pkg::sample_t             middle_row[smf3_pkg::MAX_WIDTH];
    smf3_pkg::sample_t             win[9] = '{default: '0};
    int unsigned                   col_pos = 0;
    int unsigned                   row_pos = 0;
    int unsigned                   backlog = 0;
    smf3_pkg::result_t             due_pixels[$];

    // Bench control and bookkeeping
    logic    src_idle   = 1'b1;
    logic    sink_idle  = 1'b1;
    int      sink_hold  = 0;
    int      mismatches = 0;
    int      items_sent = 0;
    int      pixels_checked = 0;
    int      input_stalls   = 0;
    int      settings_used  = 0;
    int      random_pixels  = 0;
    longint  cycle_count    = 0;
    smf3_pkg::result_t head_px;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("mismatch @%0t: %s", $realtime, what);
        end
    endtask

    // Insertion sort of the window by signed value; fifth smallest wins
    function automatic smf3_pkg::sample_t window_median();
        smf3_pkg::sample_t v[9];
        smf3_pkg::sample_t t;
        int      i;
        int      j;
        v = win;
        for (i = 1; i < 9; i++) begin
            t = v[i];
            j = i;
            while (j > 0 && v[j-1] > t) begin
                v[j] = v[j-1];
                j--;
            end
            v[j] = t;
        end
        return v[4];
    endfunction

    // Advance the predictor by one accepted item, queueing the result it releases
    function automatic void median_model_step(input smf3_pkg::sample_t value, input logic pad);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned ocol;
        int unsigned orow;
        int unsigned back;
        int          i;
        logic        emit;
        logic        interior;
        smf3_pkg::sample_t px;
        smf3_pkg::result_t res;
        w = cfg_width;
        if (w == 0) w = 1;
        if (w > smf3_pkg::MAX_WIDTH) w = smf3_pkg::MAX_WIDTH;
        h = (cfg_height == 0) ? 1 : cfg_height;
        // a pad with nothing waiting is dropped
        if (pad && backlog == 0) return;
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        px = pad ? smf3_pkg::sample_t'(0) : value;

        // shift the window left and bring in the new column
        for (i = 0; i < 3; i++) begin
            win[i*3]   = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = upper_row[c];
        win[5] = middle_row[c];
        win[8] = px;
        upper_row[c]  = middle_row[c];
        middle_row[c] = px;

        // position of the pixel now at the window center
        if (c == 0) begin
            ocol = w - 1;
            back = 2;
        end else begin
            ocol = c - 1;
            back = 1;
        end
        orow = (r + 2 * h - back) % h;

        if (pad) begin
            emit = 1'b1;
            backlog--;
        end else if (backlog >= w + 1) begin
            emit = 1'b1;
            backlog = w + 1;
        end else begin
            emit = 1'b0;
            backlog++;
        end

        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
        // fully flushed: the next pixel opens a new volume
        if (pad && backlog == 0) begin
            col_pos = 0;
            row_pos = 0;
        end

        if (emit) begin
            interior = cfg_filter && w >= 3 && h >= 3 && ocol >= 1 && ocol + 2 <= w &&
                       orow >= 1 && orow + 2 <= h;
            res.value  = interior ? window_median() : win[4];
            res.passed = !interior;
            res.last   = (orow == h - 1) && (ocol == w - 1);
            due_pixels = {due_pixels, res};
        end
    endfunction

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %h", m_tdata));
            end else begin
                head_px = due_pixels.pop_front();
                if (m_tdata !== head_px.value)
                    report_mismatch($sformatf("value got %h want %h", m_tdata, head_px.value));
                if (m_tuser !== head_px.passed)
                    report_mismatch($sformatf("passed_through got %b want %b",
                                              m_tuser, head_px.passed));
                if (m_tlast !== head_px.last)
                    report_mismatch($sformatf("end_of_slice got %b want %b",
                                              m_tlast, head_px.last));
                pixels_checked++;
            end
        end
    end

    // Result side: random or forced hold-off before each item
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (sink_hold > 0) begin
                gap = sink_hold;
                sink_hold = 0;
            end else begin
                gap = sink_idle ? $urandom_range(0, 10) : 0;
            end
            if (gap > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Offer one item, after a random gap if src_idle is set, and hold it until taken
    task automatic send_item(input smf3_pkg::sample_t value, input logic pad);
        int gap;
        gap = src_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= pad;
        @(posedge aclk);
        while (!s_tready) begin
            input_stalls++;
            @(posedge aclk);
        end
        median_model_step(value, pad);
        items_sent++;
    endtask

    // Mix of full-range, small, extreme, repeated and coarse multiples of 65536
    function automatic smf3_pkg::sample_t pick_sample(input smf3_pkg::sample_t prev);
        case ($urandom_range(0, 9)) inside
            [0:4]:   return smf3_pkg::sample_t'($urandom);
            [5:6]:   return smf3_pkg::sample_t'($urandom_range(0, 20)) - 10;
            7:       return $urandom_range(0, 1) ? smf3_pkg::sample_t'(32'h8000_0000)
                                                 : smf3_pkg::sample_t'(32'h7FFF_FFFF);
            8:       return prev;
            default: return smf3_pkg::sample_t'(($urandom_range(0, 64) - 32) <<< 16);
        endcase
    endfunction

    // Stream pixels; one_in > 0 slips in a pad about once per one_in items
    task automatic send_pixels(input int count, input int one_in);
        smf3_pkg::sample_t last_px;
        logic    pad;
        last_px = '0;
        repeat (count) begin
            pad = (one_in > 0) && ($urandom_range(0, one_in - 1) == 0);
            last_px = pick_sample(last_px);
            send_item(last_px, pad);
        end
    endtask

    // Push out every waiting pixel with pads, sometimes one ignored pad more
    task automatic flush_volume();
        while (backlog > 0) send_item(smf3_pkg::sample_t'($urandom), 1'b1);
        repeat ($urandom_range(0, 1)) send_item(smf3_pkg::sample_t'($urandom), 1'b1);
    endtask

    // Drop valid, wait for all predicted results, then let the pipeline empty
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (due_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_read(input logic [1:0] idx, output logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        value = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] got;
        reg_read(idx, got);
        if (got !== want)
            report_mismatch($sformatf("register %0d reads %h want %h", idx, got, want));
    endtask

    // Write a register, mirror it in the predictor and read it back
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] want;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            smf3_pkg::REG_IMAGE_WIDTH: begin
                cfg_width = value[smf3_pkg::COL_BITS-1:0];
                want = 32'(cfg_width);
            end
            smf3_pkg::REG_IMAGE_HEIGHT: begin
                cfg_height = value[smf3_pkg::ROW_BITS-1:0];
                want = 32'(cfg_height);
            end
            default: begin
                cfg_filter = value[0];
                want = 32'(cfg_filter);
            end
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_reg(idx, want);
    endtask

    task automatic set_geometry(input int w, input int h, input logic en);
        wait_drained();
        reg_write(smf3_pkg::REG_IMAGE_WIDTH, 32'(w));
        reg_write(smf3_pkg::REG_IMAGE_HEIGHT, 32'(h));
        reg_write(smf3_pkg::REG_FILTER_ENABLE, 32'(en));
        settings_used++;
    endtask

    task automatic test_register_defaults();
        check_reg(smf3_pkg::REG_IMAGE_WIDTH, 32'd256);
        check_reg(smf3_pkg::REG_IMAGE_HEIGHT, 32'd256);
        check_reg(smf3_pkg::REG_FILTER_ENABLE, 32'd1);
    endtask

    // Full-scale values, a pad inside the slice, then an ignored pad after flush
    task automatic test_extreme_samples();
        smf3_pkg::sample_t corner_vals[12] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000,
                                               32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0001_0000,
                                               32'shFFFF_0000, 32'sh8000_0001, 32'sh7FFF_FFFE,
                                               32'shAAAA_AAAA, 32'sh5555_5555, 32'shFFFF_FFFE};
        int k;
        set_geometry(4, 3, 1'b1);
        for (k = 0; k < 12; k++) send_item(corner_vals[k], k == 9);
        while (backlog > 0) send_item(smf3_pkg::sample_t'(32'h0F0F_0F0F), 1'b1);
        send_item(smf3_pkg::sample_t'(32'hF0F0_F0F0), 1'b1);
    endtask

    // Zero width and height behave as one: every pixel is its own slice
    task automatic test_degenerate_size();
        set_geometry(0, 0, 1'b1);
        send_item(smf3_pkg::sample_t'(32'h1234_5678), 1'b0);
        send_item(smf3_pkg::sample_t'(32'h8765_4321), 1'b0);
        flush_volume();
    endtask

    // Oversized width clamps to the widest row; a short run is pushed out by pads
    task automatic test_widest_row();
        src_idle  = 1'b0;
        sink_idle = 1'b1;
        set_geometry(2047, 65535, 1'b1);
        send_pixels(WIDE_PIXELS, 0);
        flush_volume();
        src_idle = 1'b1;
    endtask

    // Hold the result side for a long stretch while pixels keep coming
    task automatic test_output_hold();
        src_idle  = 1'b0;
        sink_idle = 1'b1;
        set_geometry(5, 4, 1'b1);
        sink_hold = 300;
        send_pixels(60, 0);
        flush_volume();
        src_idle = 1'b1;
    endtask

    // Pause the source mid-volume until every released result is out
    task automatic test_source_pause();
        set_geometry(6, 5, 1'b1);
        send_pixels(17, 0);
        wait_drained();
        send_pixels(13, 0);
        flush_volume();
    endtask

    // Random geometries and volumes, mostly whole slices with random content
    task automatic test_random_volumes();
        int   w;
        int   h;
        int   ew;
        int   eh;
        int   rows;
        int   n;
        logic en;
        while (random_pixels < RANDOM_PIXELS) begin
            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 2);
                1:       w = $urandom_range(13, 24);
                default: w = $urandom_range(3, 12);
            endcase
            case ($urandom_range(0, 9))
                0:       h = $urandom_range(0, 2);
                1:       h = 65535;
                default: h = $urandom_range(3, 7);
            endcase
            en = ($urandom_range(0, 3) != 0);
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            set_geometry(w, h, en);
            repeat ($urandom_range(1, 2)) begin
                ew = (w == 0) ? 1 : w;
                eh = (h == 0) ? 1 : h;
                rows = (eh > 8) ? $urandom_range(2, 6) : eh * $urandom_range(1, 2);
                n = ew * rows;
                if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
                send_pixels(n, 40);
                flush_volume();
                random_pixels += n;
            end
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_register_defaults();
        test_extreme_samples();
        test_degenerate_size();
        test_output_hold();
        test_source_pause();
        test_random_volumes();
        test_widest_row();
        wait_drained();

        $display("summary: %0d items sent, %0d results checked, %0d register settings",
                 items_sent, pixels_checked, settings_used);
        $display("summary: extremes, degenerate and widest sizes, %0d input stall cycles",
                 input_stalls);
        if (mismatches == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
